[rtl/bmf_pkg.sv]
// Shared types and constants for the binomial-mod-prime factorial table block.
// No dependencies.
package bmf_pkg;

  localparam int unsigned VAL_W         = 31;
  localparam int unsigned N_W           = 10;
  localparam int unsigned DEPTH_DEFAULT = 1024;
  localparam int unsigned CNT_W         = 5;

  localparam logic [VAL_W-1:0] MODULUS_RESET = 31'd1000000007;

  localparam logic CFG_MODULUS   = 1'b0;
  localparam logic CFG_TABLE_TOP = 1'b1;

  localparam logic FUNC_BUILD = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic           func;
    logic [N_W-1:0] set_size;
    logic [N_W-1:0] subset_size;
  } in_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] coefficient;
    logic             status;
  } out_rsp_t;

  // request to the shared modular multiplier; a must already be below m
  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] res;
  } mul_rsp_t;

endpackage

[rtl/bmf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmf_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/bmf_mulmod.sv]
// Bit-serial modular multiplier: res = a * b mod m, one bit of b per cycle.
// Depends on bmf_pkg. Requires a < m; b may be any value.
module bmf_mulmod (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bmf_pkg::mul_req_t       req_i,
  input  logic [bmf_pkg::VAL_W-1:0] m_i,
  output bmf_pkg::mul_rsp_t       rsp_o
);
  import bmf_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [VAL_W-1:0] a_q, a_d, b_q, b_d, r_q, r_d;
  logic [VAL_W:0]   dbl, sum;
  logic [VAL_W-1:0] r2;

  // r <- (2r + bit*a) mod m, both partial values stay below 2m
  always_comb begin
    dbl = {r_q, 1'b0};
    r2  = (dbl >= {1'b0, m_i}) ? VAL_W'(dbl - {1'b0, m_i}) : VAL_W'(dbl);
    sum = {1'b0, r2} + (b_q[VAL_W-1] ? {1'b0, a_q} : '0);
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    r_d    = r_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(VAL_W - 1);
      a_d    = req_i.a;
      b_d    = req_i.b;
      r_d    = '0;
    end else if (busy_q) begin
      r_d = (sum >= {1'b0, m_i}) ? VAL_W'(sum - {1'b0, m_i}) : VAL_W'(sum);
      b_d = {b_q[VAL_W-2:0], 1'b0};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    r_q <= r_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = r_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("multiplier started while busy");
  a_res_below_m: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (r_q < m_i))
    else $error("multiplier result not reduced");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("done without a running multiply");

endmodule

[rtl/binomial_mod_prime_factorial_table_top.sv]
// Top level: sequencer, config registers, factorial and inverse-factorial RAMs.
// Depends on bmf_pkg, bmf_ram, bmf_mulmod.
// One request at a time: stall is high from accept until the result is taken.
// Query: reads fact[n], inv[k] and inv[n-k], then three multiplies; error or k > n
// goes straight to the output state. Build: 2 * top multiplies plus up to 62 for the inverse.
// Reset clears control state only; table contents are undefined until the first build.
module binomial_mod_prime_factorial_table_top #(
  parameter int unsigned TABLE_DEPTH = bmf_pkg::DEPTH_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  bmf_pkg::in_req_t          in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output bmf_pkg::out_rsp_t         out_rsp_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [bmf_pkg::VAL_W-1:0] cfg_data_i
);
  import bmf_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned IW = AW + 1;

  typedef enum logic [13:0] {
    S_IDLE  = 14'h0001,
    S_B_CHK = 14'h0002,
    S_F_MUL = 14'h0004,
    S_P_CHK = 14'h0008,
    S_P_MR  = 14'h0010,
    S_P_MB  = 14'h0020,
    S_I_CHK = 14'h0040,
    S_I_MUL = 14'h0080,
    S_Q_RD  = 14'h0100,
    S_Q_A   = 14'h0200,
    S_Q_M1  = 14'h0400,
    S_Q_M2  = 14'h0800,
    S_Q_M3  = 14'h1000,
    S_OUT   = 14'h2000
  } state_e;

  state_e state_q, state_d;

  logic [VAL_W-1:0] modulus_q, table_top_cfg_q;
  logic [N_W-1:0]   table_top_q;
  logic [VAL_W-1:0] m_q, m_d, one;
  logic [AW-1:0]    top_q, top_d, built_top_q, built_top_d;
  logic             valid_q, valid_d;
  logic [IW-1:0]    i_q, i_d;
  logic [VAL_W-1:0] acc_q, acc_d, base_q, base_d, r_q, r_d, e_q, e_d, fact_q, fact_d;
  logic [N_W-1:0]   nk_q, nk_d;
  out_rsp_t         rsp_q, rsp_d;
  mul_req_t         mreq_q, mreq_d;
  mul_rsp_t         mrsp;

  logic             fwe_q, fwe_d, iwe_q, iwe_d;
  logic [AW-1:0]    fwa_q, fwa_d, iwa_q, iwa_d, fra_q, fra_d, ira_q, ira_d;
  logic [VAL_W-1:0] fwd_q, fwd_d, iwd_q, iwd_d, frd, ird;
  logic             q_err;

  assign one = (m_q == VAL_W'(1)) ? '0 : VAL_W'(1);
  assign table_top_cfg_q = VAL_W'(table_top_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= MODULUS_RESET;
      table_top_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODULUS:   modulus_q   <= cfg_data_i;
        CFG_TABLE_TOP: table_top_q <= cfg_data_i[N_W-1:0];
        default:       modulus_q   <= modulus_q;
      endcase
    end
  end

  assign q_err = !valid_q || (32'(in_req_i.set_size) > 32'(built_top_q))
              || (32'(in_req_i.set_size) >= 32'(TABLE_DEPTH));

  always_comb begin
    state_d     = state_q;
    m_d         = m_q;
    top_d       = top_q;
    built_top_d = built_top_q;
    valid_d     = valid_q;
    i_d         = i_q;
    acc_d       = acc_q;
    base_d      = base_q;
    r_d         = r_q;
    e_d         = e_q;
    fact_d      = fact_q;
    nk_d        = nk_q;
    rsp_d       = rsp_q;
    mreq_d      = '{start: 1'b0, a: mreq_q.a, b: mreq_q.b};
    fwe_d       = 1'b0;
    fwa_d       = fwa_q;
    fwd_d       = fwd_q;
    iwe_d       = 1'b0;
    iwa_d       = iwa_q;
    iwd_d       = iwd_q;
    fra_d       = fra_q;
    ira_d       = ira_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          m_d = (modulus_q < VAL_W'(2)) ? VAL_W'(1) : modulus_q;
          if (in_req_i.func == FUNC_BUILD) begin
            top_d = (32'(table_top_cfg_q) >= 32'(TABLE_DEPTH)) ? AW'(TABLE_DEPTH - 1)
                                                               : AW'(table_top_q);
            acc_d = (m_d == VAL_W'(1)) ? '0 : VAL_W'(1);
            fwe_d = 1'b1;
            fwa_d = '0;
            fwd_d = acc_d;
            i_d   = IW'(1);
            state_d = S_B_CHK;
          end else if (q_err) begin
            rsp_d   = '{coefficient: '0, status: STATUS_ERR};
            state_d = S_OUT;
          end else if (in_req_i.subset_size > in_req_i.set_size) begin
            rsp_d   = '{coefficient: '0, status: STATUS_OK};
            state_d = S_OUT;
          end else begin
            fra_d   = AW'(in_req_i.set_size);
            ira_d   = AW'(in_req_i.subset_size);
            nk_d    = in_req_i.set_size - in_req_i.subset_size;
            state_d = S_Q_RD;
          end
        end
      end
      // factorial fill, upward
      S_B_CHK: begin
        if (i_q > {1'b0, top_q}) begin
          base_d  = acc_q;
          r_d     = one;
          e_d     = (m_q >= VAL_W'(2)) ? m_q - VAL_W'(2) : '0;
          state_d = S_P_CHK;
        end else begin
          mreq_d  = '{start: 1'b1, a: acc_q, b: VAL_W'(i_q)};
          state_d = S_F_MUL;
        end
      end
      S_F_MUL: begin
        if (mrsp.done) begin
          acc_d   = mrsp.res;
          fwe_d   = 1'b1;
          fwa_d   = AW'(i_q);
          fwd_d   = mrsp.res;
          i_d     = i_q + 1'b1;
          state_d = S_B_CHK;
        end
      end
      // square-and-multiply for the inverse of the top factorial
      S_P_CHK: begin
        if (e_q == '0) begin
          iwe_d   = 1'b1;
          iwa_d   = top_q;
          iwd_d   = r_q;
          acc_d   = r_q;
          i_d     = IW'(top_q);
          state_d = S_I_CHK;
        end else if (e_q[0]) begin
          mreq_d  = '{start: 1'b1, a: r_q, b: base_q};
          state_d = S_P_MR;
        end else begin
          mreq_d  = '{start: 1'b1, a: base_q, b: base_q};
          state_d = S_P_MB;
        end
      end
      S_P_MR: begin
        if (mrsp.done) begin
          r_d     = mrsp.res;
          mreq_d  = '{start: 1'b1, a: base_q, b: base_q};
          state_d = S_P_MB;
        end
      end
      S_P_MB: begin
        if (mrsp.done) begin
          base_d  = mrsp.res;
          e_d     = e_q >> 1;
          state_d = S_P_CHK;
        end
      end
      // inverse-factorial fill, downward
      S_I_CHK: begin
        if (i_q == '0) begin
          built_top_d = top_q;
          valid_d     = 1'b1;
          rsp_d       = '{coefficient: '0, status: STATUS_OK};
          state_d     = S_OUT;
        end else begin
          mreq_d  = '{start: 1'b1, a: acc_q, b: VAL_W'(i_q)};
          state_d = S_I_MUL;
        end
      end
      S_I_MUL: begin
        if (mrsp.done) begin
          acc_d   = mrsp.res;
          iwe_d   = 1'b1;
          iwa_d   = AW'(i_q - 1'b1);
          iwd_d   = mrsp.res;
          i_d     = i_q - 1'b1;
          state_d = S_I_CHK;
        end
      end
      S_Q_RD: state_d = S_Q_A;
      S_Q_A: begin
        fact_d  = frd;
        // reduce inv[k] below the current modulus first
        mreq_d  = '{start: 1'b1, a: one, b: ird};
        ira_d   = AW'(nk_q);
        state_d = S_Q_M1;
      end
      S_Q_M1: begin
        if (mrsp.done) begin
          mreq_d  = '{start: 1'b1, a: mrsp.res, b: fact_q};
          state_d = S_Q_M2;
        end
      end
      S_Q_M2: begin
        if (mrsp.done) begin
          mreq_d  = '{start: 1'b1, a: mrsp.res, b: ird};
          state_d = S_Q_M3;
        end
      end
      S_Q_M3: begin
        if (mrsp.done) begin
          rsp_d   = '{coefficient: mrsp.res, status: STATUS_OK};
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      built_top_q <= '0;
      valid_q     <= 1'b0;
      mreq_q      <= '0;
      fwe_q       <= 1'b0;
      iwe_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      built_top_q <= built_top_d;
      valid_q     <= valid_d;
      mreq_q      <= mreq_d;
      fwe_q       <= fwe_d;
      iwe_q       <= iwe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    top_q  <= top_d;
    i_q    <= i_d;
    acc_q  <= acc_d;
    base_q <= base_d;
    r_q    <= r_d;
    e_q    <= e_d;
    fact_q <= fact_d;
    nk_q   <= nk_d;
    rsp_q  <= rsp_d;
    fwa_q  <= fwa_d;
    fwd_q  <= fwd_d;
    iwa_q  <= iwa_d;
    iwd_q  <= iwd_d;
    fra_q  <= fra_d;
    ira_q  <= ira_d;
  end

  bmf_mulmod u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq_q),
    .m_i    (m_q),
    .rsp_o  (mrsp)
  );

  bmf_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_fact_ram (
    .clk_i   (clk_i),
    .we_i    (fwe_q),
    .waddr_i (fwa_q),
    .wdata_i (fwd_q),
    .raddr_i (fra_q),
    .rdata_o (frd)
  );

  bmf_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_inv_ram (
    .clk_i   (clk_i),
    .we_i    (iwe_q),
    .waddr_i (iwa_q),
    .wdata_i (iwd_q),
    .raddr_i (ira_q),
    .rdata_o (ird)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_rsp_o   = rsp_q;

  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request accepted while a result is pending");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status == STATUS_ERR) |-> (out_rsp_o.coefficient == '0))
    else $error("error result with nonzero coefficient");
  a_coef_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.coefficient < m_q))
    else $error("coefficient not reduced");
  a_mul_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mrsp.done |-> (state_q == S_F_MUL || state_q == S_P_MR || state_q == S_P_MB
                   || state_q == S_I_MUL || state_q == S_Q_M1 || state_q == S_Q_M2
                   || state_q == S_Q_M3))
    else $error("multiplier result with no consumer");

endmodule
